FILE: rtl/fisr_pkg.sv
`timescale 1ns / 1ps
// types, constants and helper functions for the reciprocal square root pipeline
// no dependencies; used by fisr_fop, fast_inverse_sqrt and the testbench
package fisr_pkg;

   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_DBL = 1'b0;

   localparam logic [31:0] MAGIC_SGL = 32'h5f37_5a86;
   localparam logic [63:0] MAGIC_DBL = 64'h5fe6_eb50_c7b5_37a9;
   localparam logic [63:0] HALF_SGL = 64'h0000_0000_3f00_0000;
   localparam logic [63:0] HALF_DBL = 64'h3fe0_0000_0000_0000;
   localparam logic [63:0] THREE_HALF_SGL = 64'h0000_0000_3fc0_0000;
   localparam logic [63:0] THREE_HALF_DBL = 64'h3ff8_0000_0000_0000;

   typedef struct packed {
      logic valid;
      logic dbl;
   } fisr_ctl_type;

   // unpacked operand, bit 52 of mant weighs 1
   typedef struct packed {
      logic               sign;
      logic signed [13:0] expo;
      logic [52:0]        mant;
      logic               nan;
      logic               inf;
      logic               zero;
      logic [63:0]        quiet;
   } fisr_unp_type;

   // per-item side data carried down the operation pipeline
   typedef struct packed {
      logic               spec;
      logic [63:0]        specv;
      logic               sign;
      logic               zsign;
      logic signed [13:0] expo;
   } fisr_side_type;

   function automatic fisr_unp_type unpack(input logic [63:0] raw, input logic dbl);
      fisr_unp_type u;
      logic [10:0]  ef;
      logic [51:0]  fr;
      logic         emax;
      if (dbl) begin
         ef = raw[62:52];
         fr = raw[51:0];
         u.sign = raw[63];
         emax = &raw[62:52];
         u.quiet = raw | 64'h0008_0000_0000_0000;
      end else begin
         ef = {3'b0, raw[30:23]};
         fr = {raw[22:0], 29'b0};
         u.sign = raw[31];
         emax = &raw[30:23];
         u.quiet = {32'b0, raw[31:0] | 32'h0040_0000};
      end
      u.mant = {ef != 11'd0, fr};
      u.expo = $signed({3'b0, (ef == 11'd0) ? 11'd1 : ef}) - (dbl ? 14'sd1023 : 14'sd127);
      u.nan = emax & (fr != 52'd0);
      u.inf = emax & (fr == 52'd0);
      u.zero = (ef == 11'd0) & (fr == 52'd0);
      return u;
   endfunction

   function automatic logic [63:0] default_nan(input logic dbl);
      return dbl ? 64'hfff8_0000_0000_0000 : 64'h0000_0000_ffc0_0000;
   endfunction

   function automatic logic [63:0] pack_inf(input logic sign, input logic dbl);
      return dbl ? {sign, 11'h7ff, 52'b0} : {32'b0, sign, 8'hff, 23'b0};
   endfunction

   function automatic logic [63:0] pack_zero(input logic sign, input logic dbl);
      return dbl ? {sign, 63'b0} : {32'b0, sign, 31'b0};
   endfunction

   function automatic logic [6:0] lzc106(input logic [105:0] v);
      logic [6:0] n;
      n = 7'd106;
      for (int i = 0; i < 106; i++) begin
         if (v[i]) n = 7'(105 - i);
      end
      return n;
   endfunction

endpackage

FILE: rtl/fisr_req_if.sv
`timescale 1ns / 1ps
// operand channel: valid/ready handshake with one 64-bit operand per beat
// no dependencies
interface fisr_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] operand_bits;

   modport source (output valid, output operand_bits, input ready);
   modport sink (input valid, input operand_bits, output ready);
endinterface

FILE: rtl/fisr_rsp_if.sv
`timescale 1ns / 1ps
// result channel: valid/ready handshake with one 64-bit result per beat
// no dependencies
interface fisr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_bits;

   modport source (output valid, output result_bits, input ready);
   modport sink (input valid, input result_bits, output ready);
endinterface

FILE: rtl/fisr_fop.sv
`timescale 1ns / 1ps
// five-stage ieee multiply, or add of a and -b, with round to nearest even
// depends on fisr_pkg
module fisr_fop #(
   parameter bit IS_SUB = 1'b0,
   parameter int AUX_W = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  fisr_pkg::fisr_ctl_type in_ctl,
   input  logic [63:0]          in_a,
   input  logic [63:0]          in_b,
   input  logic [AUX_W-1:0]     in_aux,
   output fisr_pkg::fisr_ctl_type out_ctl,
   output logic [63:0]          out_res,
   output logic [AUX_W-1:0]     out_aux
);

   fisr_pkg::fisr_unp_type  ua, ub;
   fisr_pkg::fisr_ctl_type  ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   logic [AUX_W-1:0]        aux1_ff, aux2_ff, aux3_ff, aux4_ff, aux5_ff;
   fisr_pkg::fisr_side_type side1_in, side1_ff, side2_ff, side3_ff, side4_in, side4_ff;
   logic [105:0]            v2_in, v2_ff, v3_ff, n4_in, n4_ff;
   logic [6:0]              lz, rs;
   logic signed [13:0]      emin, tlim, sh3_in, sh3_ff, nsh;
   logic [211:0]            wide;
   logic                    st4_in, st4_ff;
   logic [53:0]             kept, rnd;
   logic                    g, st, carry, hid, ovf;
   logic signed [13:0]      eb;
   logic [10:0]             ef;
   logic [51:0]             fr;
   logic [63:0]             res5_in, res5_ff;

   always_comb begin
      ua = fisr_pkg::unpack(in_a, in_ctl.dbl);
      ub = fisr_pkg::unpack(in_b, in_ctl.dbl);
   end

   if (IS_SUB) begin : g_add
      logic               sbe, a_big, sub_in, sub_ff;
      logic signed [13:0] d;
      logic [5:0]         dsh;
      logic [52:0]        ms, mbig_in, mbig_ff;
      logic [111:0]       alw;
      logic [55:0]        al_in, al_ff;
      logic [56:0]        sum;

      always_comb begin
         sbe = ~ub.sign;
         a_big = ($signed(ua.expo) > $signed(ub.expo)) ||
                 ((ua.expo == ub.expo) && (ua.mant >= ub.mant));
         mbig_in = a_big ? ua.mant : ub.mant;
         ms = a_big ? ub.mant : ua.mant;
         d = a_big ? $signed(ua.expo) - $signed(ub.expo) : $signed(ub.expo) - $signed(ua.expo);
         dsh = (d > 14'sd63) ? 6'd63 : d[5:0];
         // small operand aligned with guard, round and sticky below it
         alw = {ms, 3'b0, 56'b0} >> dsh;
         al_in = {alw[111:57], alw[56] | (|alw[55:0])};
         sub_in = ua.sign ^ sbe;
         side1_in.sign = a_big ? ua.sign : sbe;
         side1_in.zsign = ua.sign & sbe;
         side1_in.expo = a_big ? ua.expo : ub.expo;
         side1_in.spec = 1'b1;
         if (ua.nan) begin
            side1_in.specv = ua.quiet;
         end else if (ub.nan) begin
            side1_in.specv = ub.quiet;
         end else if (ua.inf && ub.inf && sub_in) begin
            side1_in.specv = fisr_pkg::default_nan(in_ctl.dbl);
         end else if (ua.inf) begin
            side1_in.specv = fisr_pkg::pack_inf(ua.sign, in_ctl.dbl);
         end else if (ub.inf) begin
            side1_in.specv = fisr_pkg::pack_inf(sbe, in_ctl.dbl);
         end else begin
            side1_in.spec = 1'b0;
            side1_in.specv = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mbig_ff <= mbig_in;
            al_ff <= al_in;
            sub_ff <= sub_in;
         end
      end

      always_comb begin
         if (sub_ff) sum = {1'b0, mbig_ff, 3'b0} - {1'b0, al_ff};
         else sum = {1'b0, mbig_ff, 3'b0} + {1'b0, al_ff};
         v2_in = {sum, 49'b0};
      end
   end else begin : g_mul
      logic [53:0] hh_in, hh_ff;
      logic [52:0] hl_in, hl_ff, lh_in, lh_ff;
      logic [51:0] ll_in, ll_ff;
      logic [53:0] mid;

      always_comb begin
         // 27x26 split keeps every partial product within one small multiplier
         hh_in = ua.mant[52:26] * ub.mant[52:26];
         hl_in = ua.mant[52:26] * ub.mant[25:0];
         lh_in = ua.mant[25:0] * ub.mant[52:26];
         ll_in = ua.mant[25:0] * ub.mant[25:0];
         side1_in.sign = ua.sign ^ ub.sign;
         side1_in.zsign = ua.sign ^ ub.sign;
         side1_in.expo = $signed(ua.expo) + $signed(ub.expo);
         side1_in.spec = 1'b1;
         if (ua.nan) begin
            side1_in.specv = ua.quiet;
         end else if (ub.nan) begin
            side1_in.specv = ub.quiet;
         end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
            side1_in.specv = fisr_pkg::default_nan(in_ctl.dbl);
         end else if (ua.inf || ub.inf) begin
            side1_in.specv = fisr_pkg::pack_inf(ua.sign ^ ub.sign, in_ctl.dbl);
         end else begin
            side1_in.spec = 1'b0;
            side1_in.specv = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            hh_ff <= hh_in;
            hl_ff <= hl_in;
            lh_ff <= lh_in;
            ll_ff <= ll_in;
         end
      end

      always_comb begin
         mid = {1'b0, hl_ff} + {1'b0, lh_ff};
         v2_in = {hh_ff, 52'b0} + {26'b0, mid, 26'b0} + {54'b0, ll_ff};
      end
   end

   // normalize: shift limited so the exponent does not drop below the minimum
   always_comb begin
      lz = fisr_pkg::lzc106(v2_ff);
      emin = ctl2_ff.dbl ? -14'sd1022 : -14'sd126;
      tlim = $signed(side2_ff.expo) + 14'sd1 - emin;
      sh3_in = ($signed({7'b0, lz}) <= tlim) ? $signed({7'b0, lz}) : tlim;
   end

   always_comb begin
      nsh = -sh3_ff;
      rs = (nsh > 14'sd127) ? 7'd127 : nsh[6:0];
      wide = {v3_ff, 106'b0} >> rs;
      if (sh3_ff >= 14'sd0) begin
         n4_in = v3_ff << sh3_ff[6:0];
         st4_in = 1'b0;
      end else begin
         n4_in = wide[211:106];
         st4_in = |wide[105:0];
      end
      side4_in = side3_ff;
      side4_in.expo = $signed(side3_ff.expo) + 14'sd1 - sh3_ff;
   end

   always_comb begin
      if (ctl4_ff.dbl) begin
         kept = {1'b0, n4_ff[105:53]};
         g = n4_ff[52];
         st = (|n4_ff[51:0]) | st4_ff;
      end else begin
         kept = {30'b0, n4_ff[105:82]};
         g = n4_ff[81];
         st = (|n4_ff[80:0]) | st4_ff;
      end
      rnd = kept + {53'b0, g & (st | kept[0])};
      carry = ctl4_ff.dbl ? rnd[53] : rnd[24];
      hid = ctl4_ff.dbl ? rnd[52] : rnd[23];
      eb = $signed(side4_ff.expo) + (ctl4_ff.dbl ? 14'sd1023 : 14'sd127) +
           $signed({13'b0, carry});
      ef = (carry | hid) ? eb[10:0] : 11'd0;
      if (carry) fr = '0;
      else fr = ctl4_ff.dbl ? rnd[51:0] : {29'b0, rnd[22:0]};
      ovf = (carry | hid) && (eb >= (ctl4_ff.dbl ? 14'sd2047 : 14'sd255));
      if (side4_ff.spec) begin
         res5_in = side4_ff.specv;
      end else if (!(|n4_ff) && !st4_ff) begin
         res5_in = fisr_pkg::pack_zero(side4_ff.zsign, ctl4_ff.dbl);
      end else if (ovf) begin
         res5_in = fisr_pkg::pack_inf(side4_ff.sign, ctl4_ff.dbl);
      end else if (ctl4_ff.dbl) begin
         res5_in = {side4_ff.sign, ef, fr};
      end else begin
         res5_in = {32'b0, side4_ff.sign, ef[7:0], fr[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff.valid <= in_ctl.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
         ctl3_ff.valid <= ctl2_ff.valid;
         ctl4_ff.valid <= ctl3_ff.valid;
         ctl5_ff.valid <= ctl4_ff.valid;
      end
      if (en) begin
         ctl1_ff.dbl <= in_ctl.dbl;
         ctl2_ff.dbl <= ctl1_ff.dbl;
         ctl3_ff.dbl <= ctl2_ff.dbl;
         ctl4_ff.dbl <= ctl3_ff.dbl;
         ctl5_ff.dbl <= ctl4_ff.dbl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aux1_ff <= in_aux;
         aux2_ff <= aux1_ff;
         aux3_ff <= aux2_ff;
         aux4_ff <= aux3_ff;
         aux5_ff <= aux4_ff;
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side4_in;
         v2_ff <= v2_in;
         v3_ff <= v2_ff;
         sh3_ff <= sh3_in;
         n4_ff <= n4_in;
         st4_ff <= st4_in;
         res5_ff <= res5_in;
      end
   end

   assign out_ctl = ctl5_ff;
   assign out_res = res5_ff;
   assign out_aux = aux5_ff;

endmodule

FILE: rtl/fast_inverse_sqrt.sv
`timescale 1ns / 1ps
// an operand beat passes the operand register, the float units and the result register to its result
// throughput: one operand per cycle while no held result stalls; nine chained five-stage float units set the depth
// a held result stalls the whole pipeline until the result beat is taken
// reset clears every valid bit and selects single precision
// depends on fisr_pkg, fisr_req_if, fisr_rsp_if and fisr_fop
module fast_inverse_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   fisr_req_if.sink                    req,
   fisr_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [fisr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic                   adv, csr_wr;
   logic                   dbl_ff;
   fisr_pkg::fisr_ctl_type ctl0_ff;
   logic [63:0]            op0_ff, guess, x2_res;
   logic [63:0]            y0_aux;
   logic                   rsp_valid_ff, rsp_dbl_ff;
   logic [63:0]            rsp_bits_ff;

   fisr_pkg::fisr_ctl_type ctl_b [0:8];
   logic [63:0]            x2_b [0:8];
   logic [63:0]            y_b [0:8];
   logic [63:0]            t_b [0:8];

   assign adv = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == fisr_pkg::CSR_IDX_DBL);
   assign csr_prdata = (csr_paddr[2] == fisr_pkg::CSR_IDX_DBL) ? {31'b0, dbl_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_ff <= 1'b0;
      end else if (csr_wr) begin
         dbl_ff <= csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl0_ff.valid <= req.valid;
      end
      if (adv) begin
         ctl0_ff.dbl <= dbl_ff;
         op0_ff <= req.operand_bits;
      end
   end

   // initial guess from the bit pattern, arithmetic shift then wrapping subtract
   always_comb begin
      if (ctl0_ff.dbl) begin
         guess = fisr_pkg::MAGIC_DBL - {op0_ff[63], op0_ff[63:1]};
      end else begin
         guess = {32'b0, fisr_pkg::MAGIC_SGL - {op0_ff[31], op0_ff[31:1]}};
      end
   end

   fisr_fop #(.IS_SUB(1'b0), .AUX_W(64)) u_half (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_ctl  (ctl0_ff),
      .in_a    (op0_ff),
      .in_b    (ctl0_ff.dbl ? fisr_pkg::HALF_DBL : fisr_pkg::HALF_SGL),
      .in_aux  (guess),
      .out_ctl (ctl_b[0]),
      .out_res (x2_res),
      .out_aux (y0_aux)
   );

   assign x2_b[0] = x2_res;
   assign y_b[0] = y0_aux;
   assign t_b[0] = x2_res;

   // two newton steps, four units each: x2*y, t*y, 1.5-t, y*t
   for (genvar k = 0; k < 8; k++) begin : g_newton
      localparam int PH = k % 4;
      logic [63:0]  a, b, res;
      logic [127:0] aux_o;

      if (PH == 0) begin : g_p0
         assign a = x2_b[k];
         assign b = y_b[k];
      end else if (PH == 1) begin : g_p1
         assign a = t_b[k];
         assign b = y_b[k];
      end else if (PH == 2) begin : g_p2
         assign a = ctl_b[k].dbl ? fisr_pkg::THREE_HALF_DBL : fisr_pkg::THREE_HALF_SGL;
         assign b = t_b[k];
      end else begin : g_p3
         assign a = y_b[k];
         assign b = t_b[k];
      end

      fisr_fop #(.IS_SUB(PH == 2), .AUX_W(128)) u_op (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .in_ctl  (ctl_b[k]),
         .in_a    (a),
         .in_b    (b),
         .in_aux  ({x2_b[k], y_b[k]}),
         .out_ctl (ctl_b[k+1]),
         .out_res (res),
         .out_aux (aux_o)
      );

      assign t_b[k+1] = res;
      assign x2_b[k+1] = aux_o[127:64];
      assign y_b[k+1] = (PH == 3) ? res : aux_o[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_b[8].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_bits_ff <= y_b[8];
         rsp_dbl_ff <= ctl_b[8].dbl;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.result_bits = rsp_bits_ff;

   a_single_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_dbl_ff |-> rsp_bits_ff[63:32] == 32'b0)
      else $error("single precision result has upper bits set");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !ctl0_ff.valid)
      else $error("pipeline not empty after reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> dbl_ff == $past(csr_pwdata[0]))
      else $error("precision register not updated by write");

endmodule

FILE: tb/fast_inverse_sqrt_test.sv
`timescale 1ns / 1ps
// testbench for fast_inverse_sqrt: directed and random operands in both precisions
// checked against a bit-exact float predictor; depends on fisr_pkg, the channel interfaces and fast_inverse_sqrt
module fast_inverse_sqrt_test;

   localparam int AW = fisr_pkg::CSR_AW;
   localparam logic [AW-1:0] ADDR_DBL = AW'(4 * fisr_pkg::CSR_IDX_DBL);
   localparam logic [AW-1:0] ADDR_UNMAPPED = AW'(4);
   localparam int PIPE_DRAIN = 60;
   localparam int IDLE_LIMIT = 3000;
   localparam int RSP_HOLD = 300;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   fisr_req_if req_if ();
   fisr_rsp_if rsp_if ();

   fast_inverse_sqrt dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [63:0] expected_results[$];
   logic        dbl_mode;
   int          fail_count;
   bit          no_idle;
   bit          hold_request;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- float predictor ----------------

   function automatic real to_double(input logic [31:0] f);
      real v;
      if (f[30:23] == 8'hff) return $bitstoreal({f[31], 11'h7ff, f[22:0], 29'b0});
      if (f[30:0] == 31'b0) return $bitstoreal({f[31], 63'b0});
      if (f[30:23] == 8'h00) begin
         v = real'(f[22:0]) * (2.0 ** -149);
         return f[31] ? -v : v;
      end
      return $bitstoreal({f[31], {3'b0, f[30:23]} + 11'd896, f[22:0], 29'b0});
   endfunction

   // round a double to binary32, nearest even, with subnormals and overflow
   function automatic logic [31:0] to_single(input real r);
      logic [63:0] b, sig, q, rem, half, pk;
      int e, sh;
      logic up;
      b = $realtobits(r);
      if (b[62:52] == 11'h7ff) return {b[63], 8'hff, b[51:29]};
      if (b[62:52] == 11'h000) return {b[63], 31'b0};
      e = int'(b[62:52]) - 1023 + 127;
      if (e >= 255) return {b[63], 8'hff, 23'b0};
      sig = {11'b0, 1'b1, b[51:0]};
      sh = (e >= 1) ? 29 : 30 - e;
      if (sh > 60) sh = 60;
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      up = (rem > half) || (rem == half && q[0]);
      pk = (e >= 1) ? ((64'(e) << 23) | (q & 64'h7f_ffff)) : q;
      pk = pk + 64'(up);
      return {b[63], pk[30:0]};
   endfunction

   function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
      return to_single(to_double(a) * to_double(b));
   endfunction

   function automatic logic [63:0] rsqrt_expected(input logic [63:0] op, input logic dbl);
      logic [63:0] g;
      logic [31:0] s, gs, x2s, ys, ts;
      real num, y, x2, t;
      if (dbl) begin
         g = fisr_pkg::MAGIC_DBL - {op[63], op[63:1]};
         y = $bitstoreal(g);
         num = $bitstoreal(op);
         x2 = num * $bitstoreal(fisr_pkg::HALF_DBL);
         for (int i = 0; i < 2; i++) begin
            t = x2 * y;
            t = t * y;
            t = $bitstoreal(fisr_pkg::THREE_HALF_DBL) - t;
            y = y * t;
         end
         return $realtobits(y);
      end
      s = op[31:0];
      gs = fisr_pkg::MAGIC_SGL - {s[31], s[31:1]};
      ys = gs;
      x2s = mul_single(s, fisr_pkg::HALF_SGL[31:0]);
      for (int i = 0; i < 2; i++) begin
         ts = mul_single(x2s, ys);
         ts = mul_single(ts, ys);
         ts = to_single(to_double(fisr_pkg::THREE_HALF_SGL[31:0]) - to_double(ts));
         ys = mul_single(ys, ts);
      end
      return {32'b0, ys};
   endfunction

   // ---------------- drivers ----------------

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(19) == 0) return $urandom_range(40, 12);
      if ($urandom_range(2) == 0) return $urandom_range(3, 1);
      return 0;
   endfunction

   task automatic send_operand(input logic [63:0] op);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operand_bits <= op;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(rsqrt_expected(op, dbl_mode));
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_if.valid <= 1'b0;
      req_if.operand_bits <= {$urandom, $urandom};
   endtask

   task automatic wait_drained();
      while (expected_results.size() > 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [AW-1:0] addr,
                             input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr && addr == ADDR_DBL) dbl_mode = data[0];
      if (!wr && addr == ADDR_DBL && csr_prdata !== {31'b0, dbl_mode}) begin
         $error("double_precision: expected %0h actual %0h", {31'b0, dbl_mode}, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // result side: random stalls, or one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (no_idle) begin
               rsp_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
               rsp_if.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_if.ready <= 1'b1;
               stall_left = pick_gap();
            end
            @(negedge clock);
         end
      end
   end

   // result check, one beat at a time
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("result_bits: no result expected, actual %h", rsp_if.result_bits);
            fail_count++;
         end else if (rsp_if.result_bits !== expected_results[0]) begin
            $error("result_bits: expected %h actual %h", expected_results[0],
                   rsp_if.result_bits);
            fail_count++;
            void'(expected_results.pop_front());
         end else begin
            void'(expected_results.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("fast_inverse_sqrt verification failed");
            $finish;
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_registers();
      csr_access(1'b0, ADDR_DBL, 32'b0);
      csr_access(1'b1, ADDR_DBL, 32'h0000_0001);
      csr_access(1'b0, ADDR_DBL, 32'b0);
      // only bit 0 counts
      csr_access(1'b1, ADDR_DBL, 32'hffff_fffe);
      csr_access(1'b0, ADDR_DBL, 32'b0);
      // unmapped index leaves the mode alone
      csr_access(1'b1, ADDR_UNMAPPED, 32'hffff_ffff);
      csr_access(1'b0, ADDR_DBL, 32'b0);
   endtask

   task automatic test_single_corners();
      logic [63:0] ops[$];
      ops = '{64'h0, 64'h8000_0000, 64'h7f80_0000, 64'hff80_0000, 64'h7fc0_0000,
              64'h7f80_0001, 64'h0000_0001, 64'h007f_ffff, 64'h0080_0000,
              64'h3f80_0000, 64'h4080_0000, 64'h7f7f_ffff, 64'hbf80_0000,
              64'hffff_ffff_3f80_0000};
      csr_access(1'b1, ADDR_DBL, 32'h0);
      foreach (ops[i]) send_operand(ops[i]);
      end_burst();
      wait_drained();
   endtask

   task automatic test_double_corners();
      logic [63:0] ops[$];
      ops = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
              64'hfff0_0000_0000_0000, 64'h7ff0_0000_0000_0001, 64'h0000_0000_0000_0001,
              64'h3ff0_0000_0000_0000, 64'h7fef_ffff_ffff_ffff, 64'hbff0_0000_0000_0000,
              64'hffff_ffff_ffff_ffff};
      csr_access(1'b1, ADDR_DBL, 32'h1);
      foreach (ops[i]) send_operand(ops[i]);
      end_burst();
      wait_drained();
   endtask

   function automatic logic [63:0] random_operand(input logic dbl);
      logic [63:0] v;
      v = {$urandom, $urandom};
      // mostly positive values in a sane exponent range, some raw patterns
      if ($urandom_range(3) != 0) begin
         if (dbl) v[63:52] = 12'(1023 + $urandom_range(80) - 40);
         else v[31:23] = 9'(127 + $urandom_range(60) - 30);
      end
      return v;
   endfunction

   task automatic test_random_mix();
      for (int phase = 0; phase < 8; phase++) begin
         csr_access(1'b1, ADDR_DBL,
                    {24'b0, 4'($urandom_range(15)), 3'b0, 1'(phase % 2)});
         no_idle = (phase == 3);
         repeat (90) send_operand(random_operand(dbl_mode));
         end_burst();
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      csr_access(1'b1, ADDR_DBL, 32'h1);
      hold_request = 1'b1;
      no_idle = 1'b1;
      repeat (120) send_operand(random_operand(1'b1));
      no_idle = 1'b0;
      end_burst();
      wait_drained();
   endtask

   initial begin
      fail_count = 0;
      dbl_mode = 1'b0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operand_bits = 64'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_registers();
      test_single_corners();
      test_double_corners();
      test_random_mix();
      test_backpressure();
      csr_access(1'b1, ADDR_DBL, 32'h0);
      wait_drained();
      if (fail_count == 0)
         $display("fast_inverse_sqrt verification clean");
      else
         $display("fast_inverse_sqrt verification failed");
      $finish;
   end

endmodule
